/* design/rwl_pkg.sv */
// Shared constants for the rainfall watershed labeler.
package rwl_pkg;

	localparam int MAX_ROWS_DEF = 128;
	localparam int MAX_COLS_DEF = 128;

	localparam int HGT_W = 8;
	localparam int VAL_W = 15;
	localparam logic [VAL_W-1:0] VAL_MAX = 15'h7fff;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] REG_ROWS  = 2'd0;
	localparam logic [1:0] REG_COLS  = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	localparam logic [7:0] ROWS_RST  = 8'd128;
	localparam logic [7:0] COLS_RST  = 8'd128;
	localparam logic [3:0] LIMIT_RST = 4'd9;

	localparam logic [1:0] MD_MARK  = 2'd0;
	localparam logic [1:0] MD_DIST  = 2'd1;
	localparam logic [1:0] MD_LABEL = 2'd2;

endpackage

/* design/rwl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* design/rainfall_watershed_labeler.sv */
// Top level of the rainfall watershed labeler: command port, register port, sequencer.
//
// Usage. Three APB registers: image_rows (0x0), image_cols (0x4), label_pass_limit (0x8);
// write them only while the block is idle. Commands enter on start while busy is low:
//   write pixel: stores pixel_value at pixel_index; taken every cycle, no result.
//   read label:  busy for one cycle; done pulses once S_RD has registered the
//                pixel's label and the label count of the last start.
//   start:       clears the distance and label stores (one entry a cycle over all
//                MAX_ROWS*MAX_COLS entries), then runs a descent scan, distance scans
//                (forward/backward until stable) and label scans (up to label_pass_limit
//                rounds, 1 if it is 0). done then pulses with the label count.
// Each pixel of a scan reads its centre and eight neighbours one after another through the
// single read port of each store, then takes a drain step and the write state S_FIN. A
// label scan pixel at distance 1 sweeps its neighbours a second time (S_G2) against the
// floor height before the write.
// Reset puts the registers at their defaults, leaves the height store undefined and
// makes every label read 0 until the first start completes.
// A result is on the ports for exactly one cycle; the receiver cannot hold it off.
module rainfall_watershed_labeler #(
	parameter int MAX_ROWS = rwl_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = rwl_pkg::MAX_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [13:0] pixel_index,
	input  logic [7:0]  pixel_value,
	output logic        done,
	output logic [14:0] pixel_label,
	output logic [14:0] label_count
);
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RUW   = $clog2(MAX_ROWS + 1);
	localparam int CUW   = $clog2(MAX_COLS + 1);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int NW    = RUW + CUW;
	localparam int HW    = rwl_pkg::HGT_W;
	localparam int VW    = rwl_pkg::VAL_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_CLR  = 3'd2;
	localparam logic [2:0] S_G1   = 3'd3;
	localparam logic [2:0] S_G2   = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	// Configuration registers
	logic [7:0] rows_cfg_q, cols_cfg_q;
	logic [3:0] limit_cfg_q;
	logic [RUW-1:0] rows_used_q;
	logic [CUW-1:0] cols_used_q;
	logic [NW-1:0]  n_q;
	logic [3:0]     limit_eff;
	logic           cfg_wr;

	// Sequencer state
	logic [2:0]    st_q;
	logic [1:0]    mode_q;
	logic          dir_q;
	logic [AW-1:0] p_q, clr_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic [3:0]    j_q;
	logic [3:0]    pass_q;
	logic          change_q, started_q;
	logic [13:0]   idx_q;

	// Per-pixel gather
	logic          act_s1, g2_s1, ok_s1, ctr_s1;
	logic [HW-1:0] h_c_q, floor_q;
	logic [VW-1:0] d_c_q, l_c_q, best_q, next_label_q;
	logic          found_q, flag_q;

	// Outputs
	logic          done_q;
	logic [VW-1:0] pixel_label_q, label_count_q;

	// RAM ports
	logic [AW-1:0] rd_addr, dl_waddr, nbr_addr;
	logic [HW-1:0] rd_h;
	logic [VW-1:0] rd_d, rd_l, dist_wdata, lab_wdata;
	logic          h_we, d_we, l_we;

	// Neighbour decode
	logic up, dn, lf, rt, nbr_ok, issuing;
	logic [AW:0] a1, pb, cx;

	// Consume and finish logic
	logic          cand_ok;
	logic [VW-1:0] cand_val, dist_nv, nl, lab_new;
	logic          newl, fin_d_we, fin_l_we, chg_now, last_px;
	logic [AW-1:0] p_last;
	logic          go_scan, go_done, scan_dir;
	logic [1:0]    scan_mode;
	logic          accept;

	assign accept = start && (st_q == S_IDLE);
	assign busy   = (st_q != S_IDLE);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			rwl_pkg::REG_ROWS:  prdata = {24'd0, rows_cfg_q};
			rwl_pkg::REG_COLS:  prdata = {24'd0, cols_cfg_q};
			rwl_pkg::REG_LIMIT: prdata = {28'd0, limit_cfg_q};
			default:            prdata = 32'd0;
		endcase
	end

	assign limit_eff = (limit_cfg_q == 4'd0) ? 4'd1 : limit_cfg_q;
	assign p_last    = AW'(n_q - NW'(1));

	// Neighbour position of step j_q (1..8); step 0 is the centre pixel
	always_comb begin
		up = 1'b0; dn = 1'b0; lf = 1'b0; rt = 1'b0;
		case (j_q)
			4'd1: begin up = 1'b1; lf = 1'b1; end
			4'd2: begin up = 1'b1; end
			4'd3: begin up = 1'b1; rt = 1'b1; end
			4'd4: begin lf = 1'b1; end
			4'd5: begin rt = 1'b1; end
			4'd6: begin dn = 1'b1; lf = 1'b1; end
			4'd7: begin dn = 1'b1; end
			4'd8: begin dn = 1'b1; rt = 1'b1; end
			default: begin end
		endcase
	end

	assign nbr_ok = !(up && r_q == '0) && !(dn && 32'(r_q) + 1 >= 32'(rows_used_q)) &&
		!(lf && c_q == '0) && !(rt && 32'(c_q) + 1 >= 32'(cols_used_q));
	assign pb = {1'b0, p_q};
	assign cx = (AW+1)'(cols_used_q);
	assign a1 = up ? (pb - cx) : (dn ? (pb + cx) : pb);
	assign nbr_addr = AW'(lf ? (a1 - (AW+1)'(1)) : (rt ? (a1 + (AW+1)'(1)) : a1));
	assign issuing = ((st_q == S_G1) || (st_q == S_G2)) && (j_q <= 4'd8);

	always_comb begin
		if (st_q == S_IDLE) begin
			rd_addr = AW'(pixel_index);
		end else if (j_q == 4'd0) begin
			rd_addr = p_q;
		end else begin
			rd_addr = nbr_addr;
		end
	end

	// Candidate from a returning neighbour beat
	always_comb begin
		cand_ok  = 1'b0;
		cand_val = rd_l;
		case (mode_q)
			rwl_pkg::MD_DIST: begin
				cand_ok  = (rd_h == h_c_q) && (rd_d != '0);
				cand_val = rd_d;
			end
			rwl_pkg::MD_LABEL: begin
				if (g2_s1) begin
					cand_ok = (rd_h == floor_q);
				end else if (d_c_q == '0) begin
					cand_ok = (rd_h == h_c_q);
				end else begin
					cand_ok = (rd_h == h_c_q) && (rd_d == d_c_q - VW'(1));
				end
				cand_ok = cand_ok && (rd_l != '0);
			end
			default: cand_ok = 1'b0;
		endcase
	end

	// Write decision for the current pixel
	always_comb begin
		dist_nv  = (best_q == rwl_pkg::VAL_MAX) ? rwl_pkg::VAL_MAX : best_q + VW'(1);
		nl       = (next_label_q == rwl_pkg::VAL_MAX) ? rwl_pkg::VAL_MAX :
			next_label_q + VW'(1);
		newl     = (mode_q == rwl_pkg::MD_LABEL) && (d_c_q == '0) && !found_q && (l_c_q == '0);
		lab_new  = newl ? nl : best_q;
		fin_d_we = 1'b0;
		fin_l_we = 1'b0;
		case (mode_q)
			rwl_pkg::MD_MARK:  fin_d_we = flag_q;
			rwl_pkg::MD_DIST:  fin_d_we = (d_c_q != VW'(1)) && found_q && (dist_nv != d_c_q);
			rwl_pkg::MD_LABEL: fin_l_we = (newl || found_q) && (l_c_q != lab_new);
			default: begin end
		endcase
		chg_now = change_q || (mode_q != rwl_pkg::MD_MARK && (fin_d_we || fin_l_we));
		last_px = dir_q ? (p_q == '0) : (p_q == p_last);
	end

	// What follows the end of a scan
	always_comb begin
		go_scan   = 1'b0;
		go_done   = 1'b0;
		scan_mode = mode_q;
		scan_dir  = 1'b0;
		if (st_q == S_CLR) begin
			go_scan   = (clr_q == AW'(DEPTH - 1));
			scan_mode = rwl_pkg::MD_MARK;
		end else if (st_q == S_FIN && last_px) begin
			case (mode_q)
				rwl_pkg::MD_MARK: begin
					go_scan   = 1'b1;
					scan_mode = rwl_pkg::MD_DIST;
				end
				rwl_pkg::MD_DIST: begin
					go_scan = 1'b1;
					if (!chg_now) begin
						scan_mode = rwl_pkg::MD_LABEL;
					end else begin
						scan_dir = !dir_q;
					end
				end
				rwl_pkg::MD_LABEL: begin
					if (!chg_now || (dir_q && pass_q >= limit_eff)) begin
						go_done = 1'b1;
					end else begin
						go_scan  = 1'b1;
						scan_dir = !dir_q;
					end
				end
				default: go_done = 1'b1;
			endcase
		end
	end

	assign h_we       = accept && (command == rwl_pkg::CMD_WRITE) && (32'(pixel_index) < DEPTH);
	assign d_we       = (st_q == S_CLR) || (st_q == S_FIN && fin_d_we);
	assign l_we       = (st_q == S_CLR) || (st_q == S_FIN && fin_l_we);
	assign dl_waddr   = (st_q == S_CLR) ? clr_q : p_q;
	assign dist_wdata = (st_q == S_CLR) ? '0 : ((mode_q == rwl_pkg::MD_MARK) ? VW'(1) : dist_nv);
	assign lab_wdata  = (st_q == S_CLR) ? '0 : lab_new;

	rwl_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_height (
		.clk(clk), .we(h_we), .waddr(AW'(pixel_index)), .wdata(pixel_value),
		.raddr(rd_addr), .rdata(rd_h)
	);
	rwl_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_dist (
		.clk(clk), .we(d_we), .waddr(dl_waddr), .wdata(dist_wdata),
		.raddr(rd_addr), .rdata(rd_d)
	);
	rwl_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_label (
		.clk(clk), .we(l_we), .waddr(dl_waddr), .wdata(lab_wdata),
		.raddr(rd_addr), .rdata(rd_l)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q    <= rwl_pkg::ROWS_RST;
			cols_cfg_q    <= rwl_pkg::COLS_RST;
			limit_cfg_q   <= rwl_pkg::LIMIT_RST;
			rows_used_q   <= RUW'(1);
			cols_used_q   <= CUW'(1);
			n_q           <= NW'(1);
			st_q          <= S_IDLE;
			mode_q        <= rwl_pkg::MD_MARK;
			dir_q         <= 1'b0;
			p_q           <= '0;
			clr_q         <= '0;
			r_q           <= '0;
			c_q           <= '0;
			j_q           <= '0;
			pass_q        <= '0;
			change_q      <= 1'b0;
			started_q     <= 1'b0;
			idx_q         <= '0;
			act_s1        <= 1'b0;
			g2_s1         <= 1'b0;
			ok_s1         <= 1'b0;
			ctr_s1        <= 1'b0;
			h_c_q         <= '0;
			floor_q       <= '0;
			d_c_q         <= '0;
			l_c_q         <= '0;
			best_q        <= '0;
			found_q       <= 1'b0;
			flag_q        <= 1'b0;
			next_label_q  <= '0;
			done_q        <= 1'b0;
			pixel_label_q <= '0;
			label_count_q <= '0;
		end else begin
			// register writes and effective image size
			if (cfg_wr) begin
				case (paddr[3:2])
					rwl_pkg::REG_ROWS:  rows_cfg_q  <= pwdata[7:0];
					rwl_pkg::REG_COLS:  cols_cfg_q  <= pwdata[7:0];
					rwl_pkg::REG_LIMIT: limit_cfg_q <= pwdata[3:0];
					default: begin end
				endcase
			end
			if (rows_cfg_q == 8'd0) begin
				rows_used_q <= RUW'(1);
			end else if (32'(rows_cfg_q) > MAX_ROWS) begin
				rows_used_q <= RUW'(MAX_ROWS);
			end else begin
				rows_used_q <= RUW'(rows_cfg_q);
			end
			if (cols_cfg_q == 8'd0) begin
				cols_used_q <= CUW'(1);
			end else if (32'(cols_cfg_q) > MAX_COLS) begin
				cols_used_q <= CUW'(MAX_COLS);
			end else begin
				cols_used_q <= CUW'(cols_cfg_q);
			end
			n_q <= NW'(rows_used_q) * NW'(cols_used_q);

			done_q <= 1'b0;

			// data returning in the cycle after its address
			act_s1 <= issuing;
			g2_s1  <= (st_q == S_G2);
			ok_s1  <= (j_q != 4'd0) && nbr_ok;
			ctr_s1 <= (j_q == 4'd0);
			if (act_s1) begin
				if (ctr_s1) begin
					h_c_q   <= rd_h;
					d_c_q   <= rd_d;
					l_c_q   <= rd_l;
					floor_q <= rd_h;
				end else if (ok_s1) begin
					if (mode_q == rwl_pkg::MD_MARK && h_c_q > rd_h) begin
						flag_q <= 1'b1;
					end
					if (!g2_s1 && rd_h < floor_q) begin
						floor_q <= rd_h;
					end
					if (cand_ok && (!found_q || cand_val < best_q)) begin
						best_q  <= cand_val;
						found_q <= 1'b1;
					end
				end
			end

			case (st_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= pixel_index;
						case (command)
							rwl_pkg::CMD_START: begin
								st_q         <= S_CLR;
								clr_q        <= '0;
								next_label_q <= '0;
							end
							rwl_pkg::CMD_READ: st_q <= S_RD;
							default: begin end
						endcase
					end
				end
				S_RD: begin
					done_q        <= 1'b1;
					pixel_label_q <= (started_q && 32'(idx_q) < 32'(n_q)) ? rd_l : '0;
					label_count_q <= next_label_q;
					st_q          <= S_IDLE;
				end
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
				end
				S_G1: begin
					if (j_q == 4'd9) begin
						if (mode_q == rwl_pkg::MD_LABEL && d_c_q == VW'(1)) begin
							// sweep again against the floor height
							st_q    <= S_G2;
							j_q     <= 4'd1;
							found_q <= 1'b0;
						end else begin
							st_q <= S_FIN;
						end
					end else begin
						j_q <= j_q + 4'd1;
					end
				end
				S_G2: begin
					if (j_q == 4'd9) begin
						st_q <= S_FIN;
					end else begin
						j_q <= j_q + 4'd1;
					end
				end
				S_FIN: begin
					if (newl) begin
						next_label_q <= nl;
					end
					change_q <= chg_now;
					if (!last_px) begin
						st_q    <= S_G1;
						j_q     <= '0;
						found_q <= 1'b0;
						flag_q  <= 1'b0;
						if (dir_q) begin
							p_q <= p_q - AW'(1);
							if (c_q == '0) begin
								c_q <= CW'(cols_used_q - CUW'(1));
								r_q <= r_q - RW'(1);
							end else begin
								c_q <= c_q - CW'(1);
							end
						end else begin
							p_q <= p_q + AW'(1);
							if (32'(c_q) + 1 == 32'(cols_used_q)) begin
								c_q <= '0;
								r_q <= r_q + RW'(1);
							end else begin
								c_q <= c_q + CW'(1);
							end
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase

			if (go_scan) begin
				st_q     <= S_G1;
				j_q      <= '0;
				found_q  <= 1'b0;
				flag_q   <= 1'b0;
				change_q <= 1'b0;
				mode_q   <= scan_mode;
				dir_q    <= scan_dir;
				if (scan_mode == rwl_pkg::MD_LABEL && !scan_dir) begin
					pass_q <= (mode_q == rwl_pkg::MD_LABEL) ? pass_q + 4'd1 : 4'd1;
				end
				if (scan_dir) begin
					p_q <= p_last;
					r_q <= RW'(rows_used_q - RUW'(1));
					c_q <= CW'(cols_used_q - CUW'(1));
				end else begin
					p_q <= '0;
					r_q <= '0;
					c_q <= '0;
				end
			end
			if (go_done) begin
				st_q          <= S_IDLE;
				started_q     <= 1'b1;
				done_q        <= 1'b1;
				pixel_label_q <= '0;
				label_count_q <= newl ? nl : next_label_q;
			end
		end
	end

	assign done        = done_q;
	assign pixel_label = pixel_label_q;
	assign label_count = label_count_q;

	// a result beat always has an idle gap after it
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("two result beats back to back");
	// the scan position never leaves the image in use
	a_pos_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_G1 || st_q == S_FIN) |-> (32'(p_q) < 32'(n_q)))
		else $error("scan position outside the image");
	// the neighbour step counter stays within centre plus eight neighbours plus drain
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_G1 || st_q == S_G2) |-> (j_q <= 4'd9))
		else $error("gather step out of range");
	// label rounds never exceed the limit
	a_pass_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_G1 && mode_q == rwl_pkg::MD_LABEL) |-> (pass_q <= limit_eff))
		else $error("label round count above limit");
endmodule
